@@ rtl/rcbd_pkg.sv @@
// Shared constants, types and arithmetic helpers for the ray cast boundary detector.
package rcbd_pkg;

  localparam int IMG_WIDTH       = 256;
  localparam int IMG_HEIGHT      = 256;
  localparam int MAX_RAYS        = 64;
  localparam int MAX_WINDOW_SIDE = 15;

  localparam int PIX_TOTAL = IMG_WIDTH * IMG_HEIGHT;
  localparam int ADDR_W    = $clog2(PIX_TOTAL);
  localparam int COL_W     = $clog2(IMG_WIDTH);
  localparam int ROW_W     = $clog2(IMG_HEIGHT);
  localparam int DIST_END  = IMG_HEIGHT * 256;
  localparam int D_W       = $clog2(DIST_END) + 1;
  localparam int P_W       = D_W + 17;
  localparam int OFF_W     = D_W + 2;
  localparam int XQ_W      = OFF_W + 2;
  localparam int POS_W     = XQ_W - 8;
  localparam int ORIGIN_X  = IMG_WIDTH / 2;
  localparam int ORIGIN_XQ = ORIGIN_X * 256;
  localparam int ORIGIN_YQ = (IMG_HEIGHT - 2) * 256;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_START = 19898;
  localparam int CW           = 18;
  localparam int Z_W          = 25;
  localparam int QN_W         = 30;
  localparam int DIV_STEPS    = QN_W;
  localparam int SUM_W        = 16;
  localparam int SQ_W         = 20;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int OUT_DATA_W = 24;
  localparam int QDEPTH     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FAN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAYS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIND  = 3'd6;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_RUN  = 1'b1
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] pixel;
  } q_entry_t;

  typedef struct packed {
    logic [7:0]  fan_angle_deg;
    logic [6:0]  ray_count;
    logic [7:0]  level_threshold;
    logic [11:0] march_step_q8;
    logic [3:0]  window_side;
    logic        edge_mode;
    logic [8:0]  min_origin_distance;
  } cfg_t;

  function automatic logic signed [Z_W-1:0] atan_q16(input logic [3:0] i);
    logic signed [Z_W-1:0] r;
    unique case (i)
      4'd0:  r = 25'sd2949120;
      4'd1:  r = 25'sd1740967;
      4'd2:  r = 25'sd919879;
      4'd3:  r = 25'sd466945;
      4'd4:  r = 25'sd234379;
      4'd5:  r = 25'sd117304;
      4'd6:  r = 25'sd58666;
      4'd7:  r = 25'sd29335;
      4'd8:  r = 25'sd14668;
      4'd9:  r = 25'sd7334;
      4'd10: r = 25'sd3667;
      4'd11: r = 25'sd1833;
      4'd12: r = 25'sd917;
      4'd13: r = 25'sd458;
      4'd14: r = 25'sd229;
      4'd15: r = 25'sd115;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [OFF_W-1:0] rnd15(input logic signed [P_W-1:0] v);
    logic [P_W-1:0] mag;
    logic [P_W-1:0] m;
    mag = v[P_W-1] ? P_W'(-v) : P_W'(v);
    m = (mag + P_W'(1 << 14)) >> 15;
    return v[P_W-1] ? OFF_W'(-$signed(m)) : OFF_W'($signed(m));
  endfunction

  function automatic logic signed [POS_W-1:0] rnd8(input logic signed [XQ_W-1:0] v);
    logic [XQ_W-1:0] mag;
    logic [XQ_W-1:0] m;
    mag = v[XQ_W-1] ? XQ_W'(-v) : XQ_W'(v);
    m = (mag + XQ_W'(128)) >> 8;
    return v[XQ_W-1] ? POS_W'(-$signed(m)) : POS_W'($signed(m));
  endfunction

  function automatic logic signed [15:0] clamp16(input logic signed [CW-1:0] v);
    logic signed [15:0] r;
    if (v > CW'(32767)) r = 16'sh7fff;
    else if (v < -CW'(32768)) r = 16'sh8000;
    else r = 16'(v);
    return r;
  endfunction

endpackage

@@ rtl/rcbd_front.sv @@
// Input front end: take transfers, classify load or run, and queue them.
module rcbd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic [7:0]          in_pixel,
  output logic                q_valid,
  output rcbd_pkg::q_entry_t  q_entry,
  input  logic                q_pop
);

  localparam int PTR_W = $clog2(rcbd_pkg::QDEPTH);

  rcbd_pkg::q_entry_t mem [rcbd_pkg::QDEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [PTR_W:0]   count;
  logic             push, pop;
  rcbd_pkg::q_entry_t entry;

  assign in_ready = count < (PTR_W+1)'(rcbd_pkg::QDEPTH);
  assign push     = in_valid && in_ready;
  assign q_valid  = count != '0;
  assign pop      = q_pop && q_valid;
  assign q_entry  = mem[rptr];

  always_comb begin
    entry.op    = in_cmd ? rcbd_pkg::OP_RUN : rcbd_pkg::OP_LOAD;
    entry.pixel = in_pixel;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

endmodule

@@ rtl/rcbd_back.sv @@
// Scan engine: image store, ray angle divider, CORDIC, march and window sums.
module rcbd_back (
  input  logic                              clk,
  input  logic                              rst,
  input  rcbd_pkg::cfg_t                    cfg,
  input  logic                              q_valid,
  input  rcbd_pkg::q_entry_t                q_entry,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rcbd_pkg::OUT_DATA_W-1:0]   out_data,
  output logic                              out_last
);

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_START  = 15'b000000000000010,
    S_LIMIT  = 15'b000000000000100,
    S_RAY    = 15'b000000000001000,
    S_DIV    = 15'b000000000010000,
    S_CORD   = 15'b000000000100000,
    S_MUL    = 15'b000000001000000,
    S_OFFS   = 15'b000000010000000,
    S_POS    = 15'b000000100000000,
    S_WIN    = 15'b000001000000000,
    S_WEND   = 15'b000010000000000,
    S_DECIDE = 15'b000100000000000,
    S_DIST   = 15'b001000000000000,
    S_DCMP   = 15'b010000000000000,
    S_EMIT   = 15'b100000000000000
  } state_t;

  localparam int A = rcbd_pkg::ADDR_W;
  localparam int PW = rcbd_pkg::POS_W;

  state_t state;

  logic [7:0] image [rcbd_pkg::PIX_TOTAL];
  logic [7:0] rdata;
  logic [A-1:0] load_addr, raddr;
  logic we;

  logic [7:0]  fan;
  logic [6:0]  n;
  logic [11:0] step;
  logic [3:0]  side;
  logic [2:0]  half;
  logic [7:0]  side_sq;
  logic [rcbd_pkg::SUM_W-1:0] limit;
  logic [17:0] mdsq;
  logic [6:0]  h;

  logic [rcbd_pkg::QN_W-1:0] nq;
  logic [7:0] rem, dsr;
  logic       neg;
  logic [4:0] cnt;

  logic signed [rcbd_pkg::CW-1:0]  cx, cy;
  logic signed [rcbd_pkg::Z_W-1:0] cz;
  logic signed [15:0] sn, cs;

  logic [rcbd_pkg::D_W-1:0] d;
  logic signed [rcbd_pkg::P_W-1:0] px, py;
  logic signed [rcbd_pkg::OFF_W-1:0] xoff, yoff;
  logic signed [PW-1:0] sx, sy;
  logic seen;
  logic [rcbd_pkg::COL_W-1:0] c0;
  logic [rcbd_pkg::ROW_W-1:0] r0;
  logic [3:0] wr, wc;
  logic rd_pend;
  logic [rcbd_pkg::SUM_W-1:0] sum, prev;
  logic pvalid;
  logic [rcbd_pkg::SQ_W-1:0] sqx, sqy;

  logic res_hit, res_err;
  logic [7:0] res_x, res_y;

  // combinational helpers
  logic [rcbd_pkg::D_W:0] d_adv;
  logic d_done;
  logic [8:0] rem_sh;
  logic ge;
  logic [7:0] rem_next;
  logic [rcbd_pkg::QN_W-1:0] nq_next;
  logic signed [rcbd_pkg::CW-1:0] cdx, cdy, cx_next, cy_next;
  logic signed [rcbd_pkg::Z_W-1:0] cz_next;
  logic signed [rcbd_pkg::XQ_W-1:0] xq, yq;
  logic signed [PW-1:0] x, y, half_s, wlim, hlim;
  logic fit, dup;
  logic [rcbd_pkg::SUM_W-1:0] refv, diff;
  logic signed [8:0] tmp;
  logic [8:0] tabs;
  logic [13:0] mfan;
  logic [6:0] den;
  logic signed [PW-1:0] dx, dy;
  logic signed [rcbd_pkg::SQ_W-1:0] dxe, dye;
  logic [rcbd_pkg::SQ_W:0] dsum;
  logic [rcbd_pkg::COL_W-1:0] col;
  logic [rcbd_pkg::ROW_W-1:0] row;
  logic emit_go;

  assign q_pop = (state == S_IDLE) && q_valid;
  assign we    = q_pop && (q_entry.op == rcbd_pkg::OP_LOAD);

  always_comb begin
    d_adv  = {1'b0, d} + (rcbd_pkg::D_W+1)'(step);
    d_done = d_adv >= (rcbd_pkg::D_W+1)'(rcbd_pkg::DIST_END);

    rem_sh   = {rem, nq[rcbd_pkg::QN_W-1]};
    ge       = rem_sh >= {1'b0, dsr};
    rem_next = ge ? 8'(rem_sh - {1'b0, dsr}) : rem_sh[7:0];
    nq_next  = {nq[rcbd_pkg::QN_W-2:0], ge};

    cdx = cy >>> cnt[3:0];
    cdy = cx >>> cnt[3:0];
    if (cz >= 0) begin
      cx_next = cx - cdx;
      cy_next = cy + cdy;
      cz_next = cz - rcbd_pkg::atan_q16(cnt[3:0]);
    end else begin
      cx_next = cx + cdx;
      cy_next = cy - cdy;
      cz_next = cz + rcbd_pkg::atan_q16(cnt[3:0]);
    end

    xq = rcbd_pkg::XQ_W'(rcbd_pkg::ORIGIN_XQ) + rcbd_pkg::XQ_W'(xoff);
    yq = rcbd_pkg::XQ_W'(rcbd_pkg::ORIGIN_YQ) - rcbd_pkg::XQ_W'(yoff);
    x  = rcbd_pkg::rnd8(xq);
    y  = rcbd_pkg::rnd8(yq);
    half_s = $signed(PW'(half));
    wlim   = $signed(PW'(rcbd_pkg::IMG_WIDTH)) - half_s;
    hlim   = $signed(PW'(rcbd_pkg::IMG_HEIGHT)) - half_s;
    fit = !(x < half_s || x >= wlim || y < half_s || y >= hlim);
    dup = seen && x == sx && y == sy;

    row   = r0 + rcbd_pkg::ROW_W'(wr);
    col   = c0 + rcbd_pkg::COL_W'(wc);
    raddr = A'(row * rcbd_pkg::IMG_WIDTH + col);

    refv = cfg.edge_mode ? prev : '0;
    diff = sum >= refv ? sum - refv : refv - sum;

    den  = n - 7'd1;
    tmp  = $signed({1'b0, h, 1'b0}) - $signed({2'b0, den});
    tabs = tmp < 0 ? 9'(-tmp) : 9'(tmp);
    mfan = 14'({7'd0, tabs[6:0]} * {6'd0, fan});

    dx   = sx - $signed(PW'(rcbd_pkg::ORIGIN_X));
    dy   = sy - $signed(PW'(rcbd_pkg::IMG_HEIGHT));
    dxe  = rcbd_pkg::SQ_W'(dx);
    dye  = rcbd_pkg::SQ_W'(dy);
    dsum = {1'b0, sqx} + {1'b0, sqy};

    emit_go = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (we) image[load_addr] <= q_entry.pixel;
    rdata <= image[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      load_addr <= '0;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      rd_pend <= (state == S_WIN);
      if (rd_pend) sum <= sum + rcbd_pkg::SUM_W'(rdata);
      if (state == S_EMIT && emit_go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_entry.op == rcbd_pkg::OP_LOAD) begin
              load_addr <= (load_addr == A'(rcbd_pkg::PIX_TOTAL - 1)) ? '0 : load_addr + 1'b1;
            end else begin
              load_addr <= '0;
              state     <= S_START;
            end
          end
        end
        S_START: begin
          fan     <= cfg.fan_angle_deg > 8'd180 ? 8'd180 : cfg.fan_angle_deg;
          n       <= cfg.ray_count < 7'd2 ? 7'd2 :
                     (cfg.ray_count > 7'(rcbd_pkg::MAX_RAYS) ? 7'(rcbd_pkg::MAX_RAYS)
                                                            : cfg.ray_count);
          step    <= cfg.march_step_q8 == '0 ? 12'd1 : cfg.march_step_q8;
          side    <= cfg.window_side;
          half    <= cfg.window_side[3:1];
          side_sq <= 8'({4'd0, cfg.window_side} * {4'd0, cfg.window_side});
          mdsq    <= 18'({9'd0, cfg.min_origin_distance} * {9'd0, cfg.min_origin_distance});
          h       <= '0;
          res_hit <= 1'b0;
          res_x   <= '0;
          res_y   <= '0;
          if (!cfg.window_side[0] || cfg.window_side > 4'(rcbd_pkg::MAX_WINDOW_SIDE)) begin
            res_err <= 1'b1;
            state   <= S_EMIT;
          end else begin
            res_err <= 1'b0;
            state   <= S_LIMIT;
          end
        end
        S_LIMIT: begin
          limit <= rcbd_pkg::SUM_W'({8'd0, side_sq} * {8'd0, cfg.level_threshold});
          state <= S_RAY;
        end
        S_RAY: begin
          nq     <= {mfan, 16'b0} | rcbd_pkg::QN_W'(den);
          dsr    <= {den, 1'b0};
          rem    <= '0;
          neg    <= tmp < 0;
          cnt    <= '0;
          d      <= '0;
          seen   <= 1'b0;
          pvalid <= 1'b0;
          prev   <= '0;
          state  <= S_DIV;
        end
        S_DIV: begin
          nq  <= nq_next;
          rem <= rem_next;
          cnt <= cnt + 1'b1;
          if (cnt == 5'(rcbd_pkg::DIV_STEPS - 1)) begin
            cz    <= neg ? -rcbd_pkg::Z_W'(nq_next) : rcbd_pkg::Z_W'(nq_next);
            cx    <= rcbd_pkg::CW'(rcbd_pkg::CORDIC_START);
            cy    <= '0;
            cnt   <= '0;
            state <= S_CORD;
          end
        end
        S_CORD: begin
          cx  <= cx_next;
          cy  <= cy_next;
          cz  <= cz_next;
          cnt <= cnt + 1'b1;
          if (cnt == 5'(rcbd_pkg::CORDIC_STEPS - 1)) begin
            sn    <= rcbd_pkg::clamp16(cy_next);
            cs    <= rcbd_pkg::clamp16(cx_next);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          px    <= $signed({1'b0, d}) * sn;
          py    <= $signed({1'b0, d}) * cs;
          state <= S_OFFS;
        end
        S_OFFS: begin
          xoff  <= rcbd_pkg::rnd15(px);
          yoff  <= rcbd_pkg::rnd15(py);
          state <= S_POS;
        end
        S_POS: begin
          if (!fit || dup) begin
            d <= d_adv[rcbd_pkg::D_W-1:0];
            if (d_done) begin
              res_hit <= 1'b0;
              state   <= S_EMIT;
            end else begin
              state <= S_MUL;
            end
          end else begin
            seen  <= 1'b1;
            sx    <= x;
            sy    <= y;
            r0    <= rcbd_pkg::ROW_W'(y - half_s);
            c0    <= rcbd_pkg::COL_W'(x - half_s);
            wr    <= '0;
            wc    <= '0;
            sum   <= '0;
            state <= S_WIN;
          end
        end
        S_WIN: begin
          if (wc == side - 4'd1) begin
            wc <= '0;
            if (wr == side - 4'd1) state <= S_WEND;
            else wr <= wr + 4'd1;
          end else begin
            wc <= wc + 4'd1;
          end
        end
        S_WEND: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (cfg.edge_mode && !pvalid) begin
            prev   <= sum;
            pvalid <= 1'b1;
          end else if (diff > limit) begin
            state <= S_DIST;
          end else if (cfg.edge_mode) begin
            prev <= sum;
          end
          if (!(diff > limit) || (cfg.edge_mode && !pvalid)) begin
            d <= d_adv[rcbd_pkg::D_W-1:0];
            if (d_done) begin
              res_hit <= 1'b0;
              state   <= S_EMIT;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_DIST: begin
          sqx   <= rcbd_pkg::SQ_W'(dxe * dxe);
          sqy   <= rcbd_pkg::SQ_W'(dye * dye);
          state <= S_DCMP;
        end
        S_DCMP: begin
          res_hit <= dsum >= (rcbd_pkg::SQ_W+1)'(mdsq);
          res_x   <= sx[7:0];
          res_y   <= sy[7:0];
          state   <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            out_data  <= {res_err, res_hit ? res_y : 8'd0, res_hit ? res_x : 8'd0,
                          res_hit, h[5:0]};
            out_last  <= res_err || (h == den);
            res_x     <= '0;
            res_y     <= '0;
            if (res_err || h == den) begin
              state <= S_IDLE;
            end else begin
              h     <= h + 7'd1;
              state <= S_RAY;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/ray_cast_boundary_detector.sv @@
// Loads are queued, then written to the image store as popped, one transfer per cycle while
// no run is in progress. A run passes start and limit, then per ray a setup, 30 divider steps,
// 16 CORDIC steps and an emit, plus per march sample multiply, offset and position, the window
// sum (one image store read per cycle), end and decide for a new point that fits, and distance
// states on a boundary point; input stalls when the 4-entry queue fills, emit waits on a full
// output register. Reset (rst, synchronous) empties the queue, clears load address and output
// valid, and restores register defaults; the image store holds undefined data until loaded.
module ray_cast_boundary_detector (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // pixel
  input  logic                               s_axis_tuser,  // command
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // ray_index[5:0], hit[6], point_x[14:7], point_y[22:15], error[23]
  output logic [rcbd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rcbd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rcbd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  rcbd_pkg::cfg_t     cfg;
  logic               q_valid, q_pop;
  rcbd_pkg::q_entry_t q_entry;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fan_angle_deg       <= 8'd90;
      cfg.ray_count           <= 7'd16;
      cfg.level_threshold     <= 8'd30;
      cfg.march_step_q8       <= 12'd256;
      cfg.window_side         <= 4'd3;
      cfg.edge_mode           <= 1'b1;
      cfg.min_origin_distance <= 9'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rcbd_pkg::REG_FAN:  cfg.fan_angle_deg       <= cfg_data[7:0];
        rcbd_pkg::REG_RAYS: cfg.ray_count           <= cfg_data[6:0];
        rcbd_pkg::REG_THR:  cfg.level_threshold     <= cfg_data[7:0];
        rcbd_pkg::REG_STEP: cfg.march_step_q8       <= cfg_data[11:0];
        rcbd_pkg::REG_SIDE: cfg.window_side         <= cfg_data[3:0];
        rcbd_pkg::REG_EDGE: cfg.edge_mode           <= cfg_data[0];
        rcbd_pkg::REG_MIND: cfg.min_origin_distance <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  rcbd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_cmd   (s_axis_tuser),
    .in_pixel (s_axis_tdata),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop)
  );

  rcbd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule
